// ----- hw/rtl/ccjd_pkg.sv -----
// Shared types, constants and calendar helpers for the calendar clock block.
// No dependencies; imported by every module of the block.
package ccjd_pkg;

    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int MS_W      = 27;
    localparam int STEP_W    = 28;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int ORD_W     = 9;
    localparam int JD_W      = 23;
    localparam int SEC_TOT_W = 17;   // whole seconds of the day
    localparam int MIN_TOT_W = 11;   // whole minutes of the day

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 104;

    typedef logic [YEAR_W-1:0]        year_t;
    typedef logic [MONTH_W-1:0]       month_t;
    typedef logic [DAY_W-1:0]         day_t;
    typedef logic [MS_W-1:0]          ms_t;
    typedef logic signed [STEP_W-1:0] step_t;
    typedef logic [HOUR_W-1:0]        hour_t;
    typedef logic [MINUTE_W-1:0]      minute_t;
    typedef logic [SECOND_W-1:0]      second_t;
    typedef logic [ORD_W-1:0]         ordinal_t;
    typedef logic [JD_W-1:0]          julian_t;
    typedef logic [SEC_TOT_W-1:0]     sec_tot_t;
    typedef logic [MIN_TOT_W-1:0]     min_tot_t;

    typedef enum logic {
        KIND_STEP = 1'b0,
        KIND_LOAD = 1'b1
    } kind_t;

    localparam year_t  YEAR_MIN   = 14'd1;
    localparam year_t  YEAR_MAX   = 14'd9999;
    localparam month_t MONTH_JAN  = 4'd1;
    localparam month_t MONTH_FEB  = 4'd2;
    localparam month_t MONTH_DEC  = 4'd12;
    localparam day_t   DAY_FIRST  = 5'd1;
    localparam day_t   DAY_LONG   = 5'd31;
    localparam ms_t    MS_PER_DAY = 27'd86400000;
    localparam ms_t    MS_LAST    = 27'd86399999;
    localparam step_t  STEP_MAX   = 28'sd86399999;
    localparam step_t  STEP_MIN   = -28'sd86399999;

    // divisibility by 25 through the inverse of 25 modulo 2^14
    localparam year_t INV25       = 14'd7209;
    localparam year_t DIV25_LIMIT = 14'd655;

    // exact reciprocal constants for the time-of-day split
    localparam logic [24:0] SEC_RECIP  = 25'd17179870;   // (ms >> 3) / 125
    localparam int          SEC_SHIFT  = 31;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;       // (s >> 4) / 225
    localparam int          HOUR_SHIFT = 21;
    localparam logic [15:0] MIN_RECIP  = 16'd34953;      // (s >> 2) / 15
    localparam int          MIN_SHIFT  = 19;
    localparam int          PER_SIXTY  = 60;

    localparam int JD_YEAR_MUL = 367;
    localparam int JD_OFFSET   = 1721013;

    typedef struct packed {
        year_t  year;
        month_t month;
        day_t   day;
        ms_t    ms;
    } date_time_t;

    localparam date_time_t DT_RESET = '{year: 14'd1920, month: 4'd1, day: 5'd2,
                                        ms: 27'd43200000};

    typedef struct packed {
        kind_t  kind;
        step_t  step;
        year_t  year;
        month_t month;
        day_t   day;
        ms_t    ms;
    } cmd_t;

    typedef struct packed {
        date_time_t dt;
        logic       range_error;
    } snap_t;

    typedef struct packed {
        date_time_t dt;
        hour_t      hour;
        minute_t    minute;
        second_t    second;
        ordinal_t   ordinal;
        julian_t    julian;
        logic       range_error;
    } result_t;

    function automatic logic is_leap(input year_t y);
        year_t prod;
        logic  div25;
        prod  = y * INV25;
        div25 = (prod <= DIV25_LIMIT);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic day_t month_len(input year_t y, input month_t m);
        day_t len;
        unique case (m)
            4'd2:                   len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = DAY_LONG;
        endcase
        return len;
    endfunction

    function automatic ordinal_t days_before(input month_t m);
        ordinal_t n;
        unique case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // floor(275 * m / 9)
    function automatic logic [8:0] jd_month_term(input month_t m);
        logic [8:0] n;
        unique case (m)
            4'd1:    n = 9'd30;
            4'd2:    n = 9'd61;
            4'd3:    n = 9'd91;
            4'd4:    n = 9'd122;
            4'd5:    n = 9'd152;
            4'd6:    n = 9'd183;
            4'd7:    n = 9'd213;
            4'd8:    n = 9'd244;
            4'd9:    n = 9'd275;
            4'd10:   n = 9'd305;
            4'd11:   n = 9'd336;
            4'd12:   n = 9'd366;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- hw/rtl/ccjd_date_step.sv -----
// Date and time-of-day state with load / signed step update, one item per cycle while the snapshot is not stalled.
// Depends on ccjd_pkg.
module ccjd_date_step
    import ccjd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    output logic  cmd_ready,
    input  cmd_t  cmd,
    output logic  snap_valid,
    input  logic  snap_ready,
    output snap_t snap
);

    date_time_t state_reg;
    date_time_t state_next;
    snap_t      snap_reg;
    logic       snap_valid_reg;
    logic       snap_valid_next;
    logic       err;
    logic       take;

    year_t               ld_year;
    month_t              ld_month;
    day_t                ld_day;
    day_t                ld_len;
    ms_t                 ld_ms;
    step_t               step_sat;
    logic signed [MS_W+1:0] t_sum;
    ms_t                 t_low;
    day_t                cur_len;
    month_t              prev_month;

    assign cmd_ready = !snap_valid_reg || snap_ready;
    assign take      = cmd_valid && cmd_ready;

    always_comb
    begin
        // load: clamp every field into range
        ld_year = cmd.year;
        if (ld_year < YEAR_MIN)
        begin
            ld_year = YEAR_MIN;
        end
        else if (ld_year > YEAR_MAX)
        begin
            ld_year = YEAR_MAX;
        end
        ld_month = cmd.month;
        if (ld_month < MONTH_JAN)
        begin
            ld_month = MONTH_JAN;
        end
        else if (ld_month > MONTH_DEC)
        begin
            ld_month = MONTH_DEC;
        end
        ld_len = month_len(ld_year, ld_month);
        ld_day = cmd.day;
        if (ld_day < DAY_FIRST)
        begin
            ld_day = DAY_FIRST;
        end
        else if (ld_day > ld_len)
        begin
            ld_day = ld_len;
        end
        ld_ms = (cmd.ms > MS_LAST) ? MS_LAST : cmd.ms;

        // step: clamp to less than one day, then carry or borrow one day
        step_sat = cmd.step;
        if (cmd.step > STEP_MAX)
        begin
            step_sat = STEP_MAX;
        end
        else if (cmd.step < STEP_MIN)
        begin
            step_sat = STEP_MIN;
        end
        t_sum      = $signed({2'b00, state_reg.ms}) + $signed({step_sat[STEP_W-1], step_sat});
        t_low      = t_sum[MS_W-1:0];
        cur_len    = month_len(state_reg.year, state_reg.month);
        prev_month = state_reg.month - 4'd1;

        state_next = state_reg;
        err        = 1'b0;
        if (cmd.kind == KIND_LOAD)
        begin
            state_next = '{year: ld_year, month: ld_month, day: ld_day, ms: ld_ms};
        end
        else if (t_sum >= $signed({2'b00, MS_PER_DAY}))
        begin
            if (state_reg.day >= cur_len)
            begin
                state_next.day = DAY_FIRST;
                if (state_reg.month == MONTH_DEC)
                begin
                    state_next.month = MONTH_JAN;
                    state_next.year  = state_reg.year + 14'd1;
                end
                else
                begin
                    state_next.month = state_reg.month + 4'd1;
                end
            end
            else
            begin
                state_next.day = state_reg.day + 5'd1;
            end
            state_next.ms = t_low - MS_PER_DAY;
            if (state_reg.year == YEAR_MAX && state_reg.month == MONTH_DEC
                && state_reg.day >= cur_len)
            begin
                err        = 1'b1;
                state_next = state_reg;
            end
        end
        else if (t_sum[MS_W+1])
        begin
            if (state_reg.day > DAY_FIRST)
            begin
                state_next.day = state_reg.day - 5'd1;
            end
            else if (state_reg.month > MONTH_JAN)
            begin
                state_next.month = prev_month;
                state_next.day   = month_len(state_reg.year, prev_month);
            end
            else
            begin
                state_next.month = MONTH_DEC;
                state_next.day   = DAY_LONG;
                state_next.year  = state_reg.year - 14'd1;
            end
            state_next.ms = t_low + MS_PER_DAY;
            if (state_reg.year == YEAR_MIN && state_reg.month == MONTH_JAN
                && state_reg.day == DAY_FIRST)
            begin
                err        = 1'b1;
                state_next = state_reg;
            end
        end
        else
        begin
            state_next.ms = t_low;
        end
    end

    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (take)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_ready)
        begin
            snap_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= DT_RESET;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            if (take)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            snap_reg <= '{dt: state_next, range_error: err};
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// ----- hw/rtl/ccjd_result.sv -----
// Result pipeline: day of year, Julian base and hour/minute/second split.
// Three register stages built on constant reciprocal multiplies; depends on ccjd_pkg.
module ccjd_result
    import ccjd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    snap_valid,
    output logic    snap_ready,
    input  snap_t   snap,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    // stage A: seconds of day, ordinal, Julian base
    logic       a_valid_reg;
    date_time_t a_dt_reg;
    logic       a_err_reg;
    sec_tot_t   a_sec_reg;
    ordinal_t   a_ord_reg;
    julian_t    a_jd_reg;

    // stage B: hour and minute of day
    logic       b_valid_reg;
    date_time_t b_dt_reg;
    logic       b_err_reg;
    sec_tot_t   b_sec_reg;
    ordinal_t   b_ord_reg;
    julian_t    b_jd_reg;
    hour_t      b_hour_reg;
    min_tot_t   b_min_reg;

    // stage C: result register
    logic       res_valid_reg;
    result_t    res_reg;

    logic       a_ready;
    logic       b_ready;
    logic       c_ready;
    logic       a_load;
    logic       b_load;
    logic       c_load;

    logic [48:0] sec_prod;
    logic        leap;
    ordinal_t    ord_calc;
    logic [JD_W:0] jd_year;
    logic [16:0] jd_sub;
    logic [JD_W:0] jd_calc;
    logic [14:0] y_adj;
    logic [26:0] hour_prod;
    logic [30:0] min_prod;
    min_tot_t    minute_wide;
    sec_tot_t    second_wide;

    assign c_ready    = !res_valid_reg || res_ready;
    assign b_ready    = !b_valid_reg || c_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign snap_ready = a_ready;
    assign a_load     = snap_valid && a_ready;
    assign b_load     = a_valid_reg && b_ready;
    assign c_load     = b_valid_reg && c_ready;

    always_comb
    begin
        sec_prod = 49'(snap.dt.ms[MS_W-1:3]) * 49'(SEC_RECIP);
        leap     = is_leap(snap.dt.year);
        ord_calc = ordinal_t'(snap.dt.day) + days_before(snap.dt.month)
                 + ordinal_t'((snap.dt.month > MONTH_FEB) && leap);
        // 367Y - 7(Y + [M > 2]) / 4 + 275M / 9 + D + offset
        y_adj    = 15'(snap.dt.year) + 15'(snap.dt.month > MONTH_FEB);
        jd_year  = (JD_W+1)'(snap.dt.year) * (JD_W+1)'(JD_YEAR_MUL);
        jd_sub   = (17'(y_adj) * 17'd7) >> 2;
        jd_calc  = jd_year - (JD_W+1)'(jd_sub) + (JD_W+1)'(jd_month_term(snap.dt.month))
                 + (JD_W+1)'(snap.dt.day) + (JD_W+1)'(JD_OFFSET);

        hour_prod = 27'(a_sec_reg[SEC_TOT_W-1:4]) * 27'(HOUR_RECIP);
        min_prod  = 31'(a_sec_reg[SEC_TOT_W-1:2]) * 31'(MIN_RECIP);

        minute_wide = b_min_reg - min_tot_t'(min_tot_t'(b_hour_reg) * min_tot_t'(PER_SIXTY));
        second_wide = b_sec_reg - sec_tot_t'(sec_tot_t'(b_min_reg) * sec_tot_t'(PER_SIXTY));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= snap_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                res_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_dt_reg  <= snap.dt;
            a_err_reg <= snap.range_error;
            a_sec_reg <= sec_prod[SEC_SHIFT +: SEC_TOT_W];
            a_ord_reg <= ord_calc;
            a_jd_reg  <= jd_calc[JD_W-1:0];
        end
        if (b_load)
        begin
            b_dt_reg   <= a_dt_reg;
            b_err_reg  <= a_err_reg;
            b_sec_reg  <= a_sec_reg;
            b_ord_reg  <= a_ord_reg;
            b_jd_reg   <= a_jd_reg;
            b_hour_reg <= hour_prod[HOUR_SHIFT +: HOUR_W];
            b_min_reg  <= min_prod[MIN_SHIFT +: MIN_TOT_W];
        end
        if (c_load)
        begin
            res_reg.dt          <= b_dt_reg;
            res_reg.hour        <= b_hour_reg;
            res_reg.minute      <= minute_wide[MINUTE_W-1:0];
            res_reg.second      <= second_wide[SECOND_W-1:0];
            res_reg.ordinal     <= b_ord_reg;
            res_reg.julian      <= b_jd_reg;
            res_reg.range_error <= b_err_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- hw/rtl/calendar_clock_julian_date.sv -----
// Calendar clock top level: input register, date/time state update, result pipeline.
// Depends on ccjd_pkg, ccjd_date_step and ccjd_result.
//
// Usage:
//   s_axis carries commands: tuser is the kind (0 = add a signed step in ms,
//   1 = load date and time). Every command gives exactly one result on m_axis:
//   the current date and time, its hour/minute/second split, the day of year,
//   the integer Julian base (Julian date = base + 0.5 + ms / 86400000) and, in
//   tuser, a range error flag set when a step would leave years 1 to 9999; the
//   date and time are then held.
//   Path: input register, date/time state register, then result stages A, B
//   and C. Throughput: one command per cycle while nothing stalls, set by the
//   date update, which closes through the state registers; the hour/minute/
//   second split takes two more reciprocal-multiply stages.
//   Reset: state goes to 1920-01-02 12:00:00.000 and all stages empty.
//   Stalls: when m_axis_tready is low the result holds; empty stages behind it
//   keep taking commands until the pipeline fills, then s_axis_tready drops.
module calendar_clock_julian_date
    import ccjd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // step_ms[27:0], load_year[41:28], load_month[45:42], load_day[50:46],
    // load_ms_of_day[77:51], zero pad[79:78]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // cur_year[13:0], cur_month[17:14], cur_day[22:18], cur_ms_of_day[49:23],
    // cur_hour[54:50], cur_minute[60:55], cur_second[66:61], ordinal_day[75:67],
    // julian_base[98:76], zero pad[103:99]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // range_error
    output logic                  m_axis_tuser
);

    logic    in_valid_reg;
    cmd_t    cmd_reg;
    cmd_t    cmd_in;
    logic    cmd_ready;
    logic    snap_valid;
    logic    snap_ready;
    snap_t   snap;
    result_t res;

    always_comb
    begin
        cmd_in.kind  = kind_t'(s_axis_tuser);
        cmd_in.step  = s_axis_tdata[27:0];
        cmd_in.year  = s_axis_tdata[41:28];
        cmd_in.month = s_axis_tdata[45:42];
        cmd_in.day   = s_axis_tdata[50:46];
        cmd_in.ms    = s_axis_tdata[77:51];
    end

    assign s_axis_tready = !in_valid_reg || cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg <= cmd_in;
        end
    end

    ccjd_date_step u_date_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (in_valid_reg),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd_reg),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    ccjd_result u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    assign m_axis_tdata = {5'b00000, res.julian, res.ordinal, res.second, res.minute,
                           res.hour, res.dt.ms, res.dt.day, res.dt.month, res.dt.year};
    assign m_axis_tuser = res.range_error;

endmodule

// ----- hw/rtl/ccjd_checker.sv -----
// Port-level checks for calendar_clock_julian_date, attached by bind.
// Depends on ccjd_pkg for bus widths.
module ccjd_checker
    import ccjd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    year_t    o_year;
    month_t   o_month;
    day_t     o_day;
    ms_t      o_ms;
    hour_t    o_hour;
    minute_t  o_minute;
    second_t  o_second;
    ordinal_t o_ord;

    assign o_year   = m_axis_tdata[13:0];
    assign o_month  = m_axis_tdata[17:14];
    assign o_day    = m_axis_tdata[22:18];
    assign o_ms     = m_axis_tdata[49:23];
    assign o_hour   = m_axis_tdata[54:50];
    assign o_minute = m_axis_tdata[60:55];
    assign o_second = m_axis_tdata[66:61];
    assign o_ord    = m_axis_tdata[75:67];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> o_year >= YEAR_MIN && o_year <= YEAR_MAX
            && o_month >= MONTH_JAN && o_month <= MONTH_DEC
            && o_day >= DAY_FIRST && o_day <= DAY_LONG)
        else $error("date out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> o_ms <= MS_LAST && o_hour <= 5'd23
            && o_minute <= 6'd59 && o_second <= 6'd59)
        else $error("time of day out of range");

    a_ord_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> o_ord >= 9'd1 && o_ord <= 9'd366)
        else $error("day of year out of range");

    // a range error can only be reported at either end of the calendar
    a_err_edge: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (o_year == YEAR_MAX && o_month == MONTH_DEC && o_day == DAY_LONG)
            || (o_year == YEAR_MIN && o_month == MONTH_JAN && o_day == DAY_FIRST))
        else $error("range error away from calendar limits");

endmodule

bind calendar_clock_julian_date ccjd_checker u_ccjd_checker (.*);

// ----- bench/calendar_clock_julian_date_tb.sv -----
// Testbench for calendar_clock_julian_date: directed calendar edge cases, then random walks and raw random commands.
// Depends on ccjd_pkg and the calendar_clock_julian_date RTL; checks each result field.
`timescale 1ns / 100ps

module calendar_clock_julian_date_tb;
    import ccjd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DAY_MS        = 86400000;
    localparam int LAST_MS       = 86399999;
    localparam int SETTLE_CYCLES = 12;
    localparam int CUM_DAYS[13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    // tracked date and time of the clock
    int cal_year  = 1920;
    int cal_month = 1;
    int cal_day   = 2;
    int cal_ms    = 43200000;

    result_t expected_q[$];
    int      mismatches = 0;
    int      results_checked = 0;
    int      loads_sent = 0;
    int      steps_sent = 0;
    int      holds_seen = 0;
    int      cycles = 0;
    int      burst_left = 0;
    logic [7:0] rx_tick = '0;

    calendar_clock_julian_date DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- calendar predictor ----------------

    function automatic logic leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int month_days(input int y, input int m);
        int n;
        case (m)
            2:          n = leap_year(y) ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default:    n = 31;
        endcase
        return n;
    endfunction

    function automatic result_t advance_calendar(input cmd_t c);
        int      y;
        int      m;
        int      d;
        longint  t;
        logic    held;
        result_t r;
        held = 1'b0;
        if (c.kind == KIND_LOAD)
        begin
            y = int'(c.year);
            m = int'(c.month);
            d = int'(c.day);
            t = longint'(c.ms);
            if (y < 1) y = 1;
            if (y > 9999) y = 9999;
            if (m < 1) m = 1;
            if (m > 12) m = 12;
            if (d < 1) d = 1;
            if (d > month_days(y, m)) d = month_days(y, m);
            if (t > LAST_MS) t = LAST_MS;
            cal_year  = y;
            cal_month = m;
            cal_day   = d;
            cal_ms    = int'(t);
            loads_sent++;
        end
        else
        begin
            t = {{(64-STEP_W){c.step[STEP_W-1]}}, c.step};
            if (t > LAST_MS) t = LAST_MS;
            if (t < -LAST_MS) t = -LAST_MS;
            t = t + cal_ms;
            y = cal_year;
            m = cal_month;
            d = cal_day;
            if (t >= DAY_MS)
            begin
                d++;
                if (d > month_days(y, m))
                begin
                    d = 1;
                    m++;
                    if (m > 12)
                    begin
                        m = 1;
                        y++;
                    end
                end
                t = t - DAY_MS;
            end
            else if (t < 0)
            begin
                if (d > 1)
                    d--;
                else
                begin
                    if (m > 1)
                        m--;
                    else
                    begin
                        m = 12;
                        y--;
                    end
                    d = month_days(y, m);
                end
                t = t + DAY_MS;
            end
            // leaving years 1..9999 holds the whole state
            if (y > 9999 || y < 1)
                held = 1'b1;
            else
            begin
                cal_year  = y;
                cal_month = m;
                cal_day   = d;
                cal_ms    = int'(t);
            end
            steps_sent++;
        end
        if (held)
            holds_seen++;

        r.dt.year     = year_t'(cal_year);
        r.dt.month    = month_t'(cal_month);
        r.dt.day      = day_t'(cal_day);
        r.dt.ms       = ms_t'(cal_ms);
        r.hour        = hour_t'(cal_ms / 3600000);
        r.minute      = minute_t'((cal_ms / 60000) % 60);
        r.second      = second_t'((cal_ms / 1000) % 60);
        r.ordinal     = ordinal_t'(cal_day + CUM_DAYS[cal_month]
                        + ((cal_month > 2 && leap_year(cal_year)) ? 1 : 0));
        r.julian      = julian_t'(367 * cal_year - (7 * (cal_year + (cal_month + 9) / 12)) / 4
                        + (275 * cal_month) / 9 + cal_day + 1721013);
        r.range_error = held;
        return r;
    endfunction

    // ---------------- stimulus side ----------------

    function automatic cmd_t make_load(input int y, input int m, input int d, input int ms);
        cmd_t c;
        c.kind  = KIND_LOAD;
        c.step  = step_t'($urandom);
        c.year  = year_t'(y);
        c.month = month_t'(m);
        c.day   = day_t'(d);
        c.ms    = ms_t'(ms);
        return c;
    endfunction

    function automatic cmd_t make_step(input int s);
        cmd_t c;
        c.kind  = KIND_STEP;
        c.step  = step_t'(s);
        c.year  = year_t'($urandom);
        c.month = month_t'($urandom);
        c.day   = day_t'($urandom);
        c.ms    = ms_t'($urandom);
        return c;
    endfunction

    // one transaction on the input stream; tvalid stays high for a following item
    task automatic send_cmd(input cmd_t c);
        @(negedge clk);
        s_axis_tdata  <= {2'b00, c.ms, c.day, c.month, c.year, c.step};
        s_axis_tuser  <= c.kind;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_q.push_back(advance_calendar(c));
    endtask

    // bursts of random length with random gaps between them
    task automatic issue(input cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        send_cmd(c);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // ---------------- result checking ----------------

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.dt.year     = m_axis_tdata[13:0];
            got.dt.month    = m_axis_tdata[17:14];
            got.dt.day      = m_axis_tdata[22:18];
            got.dt.ms       = m_axis_tdata[49:23];
            got.hour        = m_axis_tdata[54:50];
            got.minute      = m_axis_tdata[60:55];
            got.second      = m_axis_tdata[66:61];
            got.ordinal     = m_axis_tdata[75:67];
            got.julian      = m_axis_tdata[98:76];
            got.range_error = m_axis_tuser;
            if (expected_q.size() == 0)
                report_mismatch("result transaction with nothing outstanding");
            else
            begin
                want = expected_q.pop_front();
                results_checked++;
                check_field("cur_year", 32'(got.dt.year), 32'(want.dt.year));
                check_field("cur_month", 32'(got.dt.month), 32'(want.dt.month));
                check_field("cur_day", 32'(got.dt.day), 32'(want.dt.day));
                check_field("cur_ms_of_day", 32'(got.dt.ms), 32'(want.dt.ms));
                check_field("cur_hour", 32'(got.hour), 32'(want.hour));
                check_field("cur_minute", 32'(got.minute), 32'(want.minute));
                check_field("cur_second", 32'(got.second), 32'(want.second));
                check_field("ordinal_day", 32'(got.ordinal), 32'(want.ordinal));
                check_field("julian_base", 32'(got.julian), 32'(want.julian));
                check_field("range_error", 32'(got.range_error), 32'(want.range_error));
            end
        end
    end

    // receiver stall pattern: free running, random, sparse, then long stalls
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 8'd1;
        case (rx_tick[7:6])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(0, 9) < 7);
            2'd2:    m_axis_tready <= (rx_tick[1:0] == 2'd0);
            default: m_axis_tready <= (rx_tick[5:3] != 3'd5);
        endcase
    end

    // ---------------- tests ----------------

    task automatic test_calendar_edges();
        send_cmd(make_step(0));                      // reset state shows through
        issue(make_load(1, 1, 1, 0));
        issue(make_step(-1));                        // borrow before year 1: held
        issue(make_step(1));
        issue(make_load(9999, 12, 31, LAST_MS));
        issue(make_step(1));                         // carry past year 9999: held
        issue(make_step(-LAST_MS));
        issue(make_step(-134217728));                // most negative code, saturated
        issue(make_step(134217727));                 // most positive code, saturated
        issue(make_load(2000, 2, 28, LAST_MS));
        issue(make_step(1));                         // 400-year leap day
        issue(make_load(1900, 2, 28, LAST_MS));
        issue(make_step(1));                         // century, no leap day
        issue(make_load(2100, 3, 1, 0));
        issue(make_step(-1));
        issue(make_load(2024, 12, 31, 86399000));
        issue(make_step(1000));                      // new year
        issue(make_load(0, 0, 0, 134217727));        // all load fields below/above range
        issue(make_load(16383, 15, 31, 0));
        issue(make_load(2023, 2, 31, 5000));         // day clipped to month length
        issue(make_load(2024, 2, 30, 5000));
        issue(make_load(2023, 4, 31, 5000));
        issue(make_step(-43200000));
    endtask

    task automatic test_random_walk(input int n_items);
        int sent;
        int y;
        int m;
        int d;
        int ms;
        int n_steps;
        int s;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 9))
                0:       y = $urandom_range(1, 2);
                1:       y = $urandom_range(9998, 9999);
                2:       y = 100 * $urandom_range(1, 99);
                default: y = $urandom_range(1, 9999);
            endcase
            m  = $urandom_range(1, 12);
            d  = $urandom_range(0, 1) ? month_days(y, m) : $urandom_range(1, month_days(y, m));
            if ($urandom_range(0, 3) == 0)
                d = 1;
            case ($urandom_range(0, 3))
                0:       ms = $urandom_range(0, 5000);
                1:       ms = $urandom_range(LAST_MS - 5000, LAST_MS);
                default: ms = $urandom_range(0, LAST_MS);
            endcase
            issue(make_load(y, m, d, ms));
            sent++;
            n_steps = $urandom_range(4, 20);
            repeat (n_steps)
            begin
                case ($urandom_range(0, 5))
                    0:       s = $urandom_range(0, 4000) - 2000;
                    1:       s = $urandom_range(0, 1) ? LAST_MS : -LAST_MS;
                    default: s = $urandom_range(0, 2 * LAST_MS) - LAST_MS;
                endcase
                issue(make_step(s));
                sent++;
            end
        end
    endtask

    task automatic test_raw_noise(input int n_items);
        cmd_t c;
        repeat (n_items)
        begin
            c.kind  = kind_t'($urandom_range(0, 1));
            c.step  = step_t'($urandom);
            c.year  = year_t'($urandom);
            c.month = month_t'($urandom);
            c.day   = day_t'($urandom);
            c.ms    = ms_t'($urandom);
            issue(c);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_calendar_edges();
        wait_for_results();
        test_random_walk(180);
        test_raw_noise(60);
        wait_for_results();
        test_random_walk(120);
        test_raw_noise(40);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d loads and %0d steps, %0d held at the year limits",
                 loads_sent, steps_sent, holds_seen);
        $display("%0d results compared, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- calendar_clock_julian_date.f -----
hw/rtl/ccjd_pkg.sv
hw/rtl/ccjd_date_step.sv
hw/rtl/ccjd_result.sv
hw/rtl/calendar_clock_julian_date.sv
hw/rtl/ccjd_checker.sv
bench/calendar_clock_julian_date_tb.sv
